// ===== rtl/lsqovc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lsqovc_pkg;

   // Field widths of the request and result beats.
   localparam int ADDR_W = 48;
   localparam int ID_W   = 32;

   // Request codes.
   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_EXECUTE = 2'd1;
   localparam logic [1:0] OP_REMOVE  = 2'd2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [ID_W-1:0]   seq_id;
      logic [ADDR_W-1:0] mem_addr;
      logic [ADDR_W-1:0] inst_pc;
      logic              is_store;
   } req_beat_type;

   typedef struct packed {
      logic            accepted;
      logic            violation;
      logic [ID_W-1:0] violating_id;
      logic            forwarded;
   } rsp_beat_type;

   // Passes a request makes down the row of entries.
   typedef enum logic [1:0] {
      PH_FIND,
      PH_CMP,
      PH_WRITE
   } phase_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } ctrl_state_type;

   // Token handed from one entry to the next every cycle.
   typedef struct packed {
      logic              valid;
      phase_type         phase;
      logic [1:0]        op;
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] word;
      logic [ADDR_W-1:0] pc;
      logic              store;
      logic              fwd_self;
      logic              hit;
      logic              viol;
      logic [ID_W-1:0]   best;
      logic              fwd;
   } probe_type;

endpackage

`default_nettype wire

// ===== rtl/lsqovc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsqovc_cell #(
   parameter int WORD_W = 46
) (
   input  wire                    clock,
   input  wire                    reset,
   input  lsqovc_pkg::probe_type  probe_in,
   output lsqovc_pkg::probe_type  probe_out,
   output logic                   sel_out
);

   logic                          valid_ff, valid_in;
   logic                          sel_ff, sel_in;
   logic [WORD_W-1:0]             word_ff, word_in;
   logic [lsqovc_pkg::ID_W-1:0]   id_ff, id_in;
   logic [lsqovc_pkg::ADDR_W-1:0] pc_ff, pc_in;
   logic                          store_ff, store_in;
   logic                          exec_ff, exec_in;
   logic                          fwd_ff, fwd_in;
   lsqovc_pkg::probe_type         probe_ff, probe_in_nx;
   logic                          same_word;

   assign same_word = valid_ff && (word_ff == probe_in.word[WORD_W-1:0]);

   // Act on the token for the current pass and pass it on.
   always_comb begin
      valid_in    = valid_ff;
      sel_in      = sel_ff;
      word_in     = word_ff;
      id_in       = id_ff;
      pc_in       = pc_ff;
      store_in    = store_ff;
      exec_in     = exec_ff;
      fwd_in      = fwd_ff;
      probe_in_nx = probe_in;
      if (probe_in.valid) begin
         case (probe_in.phase)
            lsqovc_pkg::PH_FIND: begin
               if (!probe_in.hit) begin
                  if (probe_in.op == lsqovc_pkg::OP_INSERT && !valid_ff) begin
                     valid_in        = 1'b1;
                     word_in         = probe_in.word[WORD_W-1:0];
                     id_in           = probe_in.id;
                     pc_in           = probe_in.pc;
                     store_in        = probe_in.store;
                     exec_in         = 1'b0;
                     fwd_in          = 1'b0;
                     probe_in_nx.hit = 1'b1;
                  end else if (valid_ff && id_ff == probe_in.id) begin
                     if (probe_in.op == lsqovc_pkg::OP_REMOVE) begin
                        valid_in        = 1'b0;
                        probe_in_nx.hit = 1'b1;
                     end else if (probe_in.op == lsqovc_pkg::OP_EXECUTE) begin
                        sel_in               = 1'b1;
                        probe_in_nx.hit      = 1'b1;
                        probe_in_nx.word     = lsqovc_pkg::ADDR_W'(word_ff);
                        probe_in_nx.pc       = pc_ff;
                        probe_in_nx.store    = store_ff;
                        probe_in_nx.fwd_self = fwd_ff;
                     end
                  end
               end
            end
            lsqovc_pkg::PH_CMP: begin
               if (same_word && !sel_ff) begin
                  if (id_ff > probe_in.id) begin
                     if (exec_ff && pc_ff != probe_in.pc && probe_in.store && !store_ff &&
                         (!probe_in.viol || probe_in.best < id_ff)) begin
                        probe_in_nx.viol = 1'b1;
                        probe_in_nx.best = id_ff;
                     end
                  end else if (!probe_in.fwd_self && !probe_in.store && store_ff &&
                               exec_ff) begin
                     probe_in_nx.fwd = 1'b1;
                  end
               end
            end
            lsqovc_pkg::PH_WRITE: begin
               if (sel_ff) begin
                  exec_in = 1'b1;
                  fwd_in  = fwd_ff | probe_in.fwd;
                  sel_in  = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control bits are reset; entry payload is written before it is read.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         sel_ff         <= 1'b0;
         probe_ff.valid <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         sel_ff         <= sel_in;
         probe_ff.valid <= probe_in_nx.valid;
      end
      word_ff           <= word_in;
      id_ff             <= id_in;
      pc_ff             <= pc_in;
      store_ff          <= store_in;
      exec_ff           <= exec_in;
      fwd_ff            <= fwd_in;
      probe_ff.phase    <= probe_in_nx.phase;
      probe_ff.op       <= probe_in_nx.op;
      probe_ff.id       <= probe_in_nx.id;
      probe_ff.word     <= probe_in_nx.word;
      probe_ff.pc       <= probe_in_nx.pc;
      probe_ff.store    <= probe_in_nx.store;
      probe_ff.fwd_self <= probe_in_nx.fwd_self;
      probe_ff.hit      <= probe_in_nx.hit;
      probe_ff.viol     <= probe_in_nx.viol;
      probe_ff.best     <= probe_in_nx.best;
      probe_ff.fwd      <= probe_in_nx.fwd;
   end

   assign probe_out = probe_ff;
   assign sel_out   = sel_ff;

endmodule

`default_nettype wire

// ===== rtl/lsq_order_violation_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Load-store queue with memory-order violation check.
// A request beat is taken on a rising edge with start high and busy low:
// insert, execute or remove of one memory operation, keyed by seq_id.
// Exactly one result beat follows, shown on rsp_beat for a single cycle
// while rsp_strobe is high; the receiver cannot stall it.
// The entries form a row of ENTRIES cells. A request travels as a token,
// one cell per cycle. Insert and remove make one pass; their result
// follows once the token leaves the row. Execute makes three
// passes (find the entry, compare against all others, write back the
// executed and forwarded flags) and answers after the third pass;
// an execute whose id is not present answers after the first pass.
// busy stays high from the accept edge until the result is shown, so one
// request is in flight at a time; the next one is taken at the earliest at
// the edge that ends the result cycle. The row length sets the rate.
// Reset empties the queue at once and returns the block to idle.
module lsq_order_violation_check #(
   parameter int ENTRIES    = 32,
   parameter int WORD_SHIFT = 2
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   output logic                      busy,
   input  lsqovc_pkg::req_beat_type  req_beat,
   output logic                      rsp_strobe,
   output lsqovc_pkg::rsp_beat_type  rsp_beat
);

   localparam int WORD_W = lsqovc_pkg::ADDR_W - WORD_SHIFT;

   lsqovc_pkg::ctrl_state_type state_ff, state_in;
   lsqovc_pkg::probe_type      launch_ff, launch_in;
   lsqovc_pkg::probe_type      chain [ENTRIES+1];
   lsqovc_pkg::probe_type      tail;
   lsqovc_pkg::rsp_beat_type   rsp_ff, rsp_in;
   logic                       strobe_ff, strobe_in;
   logic                       tail_done;
   logic [ENTRIES-1:0]         sel_vec;

   assign chain[0] = launch_ff;
   assign tail     = chain[ENTRIES];

   // Row of queue entries.
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lsqovc_cell #(
         .WORD_W (WORD_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .probe_in  (chain[g]),
         .probe_out (chain[g+1]),
         .sel_out   (sel_vec[g])
      );
   end

   // The token leaving the row ends the request unless another pass follows.
   assign tail_done = tail.valid &&
                      !(tail.phase == lsqovc_pkg::PH_FIND &&
                        tail.op == lsqovc_pkg::OP_EXECUTE && tail.hit) &&
                      tail.phase != lsqovc_pkg::PH_CMP;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsqovc_pkg::ST_IDLE: if (start) state_in = lsqovc_pkg::ST_RUN;
         lsqovc_pkg::ST_RUN:  if (tail_done) state_in = lsqovc_pkg::ST_IDLE;
         default:             state_in = lsqovc_pkg::ST_IDLE;
      endcase
   end

   // Launch of passes and the result beat.
   always_comb begin
      launch_in       = tail;
      launch_in.valid = 1'b0;
      rsp_in          = '0;
      strobe_in       = 1'b0;
      unique case (state_ff)
         lsqovc_pkg::ST_IDLE: begin
            if (start) begin
               launch_in.valid    = 1'b1;
               launch_in.phase    = lsqovc_pkg::PH_FIND;
               launch_in.op       = req_beat.req_type;
               launch_in.id       = req_beat.seq_id;
               launch_in.word     = req_beat.mem_addr >> WORD_SHIFT;
               launch_in.pc       = req_beat.inst_pc;
               launch_in.store    = req_beat.is_store;
               launch_in.fwd_self = 1'b0;
               launch_in.hit      = 1'b0;
               launch_in.viol     = 1'b0;
               launch_in.best     = '0;
               launch_in.fwd      = 1'b0;
            end
         end
         lsqovc_pkg::ST_RUN: begin
            if (tail_done) begin
               strobe_in       = 1'b1;
               rsp_in.accepted = tail.hit;
               if (tail.phase == lsqovc_pkg::PH_WRITE) begin
                  rsp_in.violation    = tail.viol;
                  rsp_in.violating_id = tail.best;
                  rsp_in.forwarded    = tail.fwd;
               end
            end else if (tail.valid) begin
               launch_in.valid = 1'b1;
               launch_in.phase = (tail.phase == lsqovc_pkg::PH_FIND) ?
                                 lsqovc_pkg::PH_CMP : lsqovc_pkg::PH_WRITE;
            end
         end
         default: begin
         end
      endcase
   end

   // Controller state, launch register and result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= lsqovc_pkg::ST_IDLE;
         launch_ff.valid <= 1'b0;
         strobe_ff       <= 1'b0;
      end else begin
         state_ff        <= state_in;
         launch_ff.valid <= launch_in.valid;
         strobe_ff       <= strobe_in;
      end
      launch_ff.phase    <= launch_in.phase;
      launch_ff.op       <= launch_in.op;
      launch_ff.id       <= launch_in.id;
      launch_ff.word     <= launch_in.word;
      launch_ff.pc       <= launch_in.pc;
      launch_ff.store    <= launch_in.store;
      launch_ff.fwd_self <= launch_in.fwd_self;
      launch_ff.hit      <= launch_in.hit;
      launch_ff.viol     <= launch_in.viol;
      launch_ff.best     <= launch_in.best;
      launch_ff.fwd      <= launch_in.fwd;
      rsp_ff             <= rsp_in;
   end

   assign busy       = (state_ff != lsqovc_pkg::ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_beat   = rsp_ff;

`ifndef SYNTH
   a_one_selected: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel_vec))
      else $error("more than one entry selected for execute");

   a_token_busy: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> busy)
      else $error("token left the row while idle");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && sel_vec == '0)
      else $error("result shown with work still pending");
`endif

endmodule

`default_nettype wire
